>>> rtl/core/signed_integer_to_radix_digits_assert.svh
// assertion macros used by the checker of the radix conversion block
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
// consequent checked in the same cycle as the antecedent
`define I2R_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// consequent checked in the cycle after the antecedent
`define I2R_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> rtl/core/i2r_pkg.sv
// shared types, constants and the digit symbol lookup of the radix conversion block
package i2r_pkg;

	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int CHAR_W      = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;
	// dividend bits retired per divider cycle
	localparam int DIV_STEP    = 8;

	localparam logic [CHAR_W-1:0]     MINUS_CHAR      = 8'h2D;
	localparam logic [RADIX_W-1:0]    RADIX_RESET     = 5'd10;
	localparam logic [RADIX_W-1:0]    RADIX_MIN       = 5'd2;
	localparam logic [CFG_DATA_W-1:0] CHARS_LOW_RESET  = 64'h3736353433323130;
	localparam logic [CFG_DATA_W-1:0] CHARS_HIGH_RESET = 64'h6665646362613938;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RADIX      = 2'd0,
		REG_CHARS_LOW  = 2'd1,
		REG_CHARS_HIGH = 2'd2
	} cfg_reg_t;

	// settings seen by the conversion engine
	typedef struct packed {
		logic [RADIX_W-1:0]    radix;
		logic [CFG_DATA_W-1:0] chars_low;
		logic [CFG_DATA_W-1:0] chars_high;
	} cfg_t;

	// character of one digit value from the alphabet registers
	function automatic logic [CHAR_W-1:0] symbol_of(input logic [DIGIT_W-1:0] d,
		input cfg_t c);
		logic [2*CFG_DATA_W-1:0] tab;
		tab = {c.chars_high, c.chars_low};
		return tab[{d, 3'b000} +: CHAR_W];
	endfunction

endpackage

>>> rtl/core/i2r_in_if.sv
// input channel carrying one signed value per transfer
interface i2r_in_if #(
	parameter int VALUE_WIDTH = 32
) ();
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

>>> rtl/core/i2r_out_if.sv
// output channel carrying one character per transfer
interface i2r_out_if import i2r_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

>>> rtl/core/i2r_ram.sv
// generic single write port ram with registered read
module i2r_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/core/i2r_front.sv
// front end: takes values and splits them into sign and magnitude
module i2r_front import i2r_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	i2r_in_if.sink             din,
	output logic               push_valid,
	input  logic               push_ready,
	output logic [VALUE_WIDTH:0] push_data
);
	logic                   neg;
	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;

	// two's complement magnitude, the most negative value maps to its own pattern
	assign raw = din.value;
	assign neg = raw[VALUE_WIDTH-1];
	assign mag = neg ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;

	// hand the classified value to the queue
	assign push_valid = din.valid;
	assign din.ready  = push_ready;
	assign push_data  = {neg, mag};
endmodule

>>> rtl/core/i2r_fifo.sv
// short queue between front end and conversion engine
module i2r_fifo #(
	parameter int DATA_W = 33,
	parameter int DEPTH  = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != (PTR_W+1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

>>> rtl/core/i2r_back.sv
// conversion engine: repeated division by the radix, then characters most significant first
module i2r_back import i2r_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  logic [VALUE_WIDTH:0] pop_data,
	i2r_out_if.source            dout
);
	localparam int NCH   = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
	localparam int PAD_W = NCH * DIV_STEP;
	localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [PAD_W-1:0]   div_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [CH_W-1:0]    chunk_q;
	logic [CNT_W-1:0]   count_q;
	logic [AW-1:0]      idx_q;
	logic               neg_q;
	logic               ovalid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic [DIGIT_W-1:0] rem_c [DIV_STEP+1];
	logic [DIV_STEP-1:0] qbits;
	logic [DIGIT_W:0]   trial;
	logic [PAD_W-1:0]   next_div;
	logic               last_chunk;
	logic               out_free;
	logic [CNT_W-1:0]   cnt_m1;
	logic [AW-1:0]      idx_m1;
	logic               ram_we;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [DIGIT_W-1:0] ram_rdata;

	// restoring division of one chunk of dividend bits by the radix
	always_comb begin
		rem_c[0] = rem_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			trial = {rem_c[i], div_q[PAD_W-1-i]};
			qbits[DIV_STEP-1-i] = (trial >= cfg.radix);
			rem_c[i+1] = qbits[DIV_STEP-1-i] ? DIGIT_W'(trial - cfg.radix)
				: trial[DIGIT_W-1:0];
		end
	end

	// quotient bits shift in behind the dividend
	assign next_div   = (div_q << DIV_STEP) | PAD_W'(qbits);
	assign last_chunk = (chunk_q == CH_W'(NCH-1));
	assign out_free   = !ovalid_q || dout.ready;
	assign cnt_m1     = count_q - 1'b1;
	assign idx_m1     = idx_q - 1'b1;
	assign pop_ready  = (state_q == ST_IDLE);

	// digit buffer ports
	assign ram_we    = (state_q == ST_DIV) && last_chunk
		&& (count_q != CNT_W'(MAX_DIGITS));
	assign ram_re    = (state_q == ST_SIGN)
		|| ((state_q == ST_EMIT) && out_free && (idx_q != '0));
	assign ram_raddr = (state_q == ST_SIGN) ? cnt_m1[AW-1:0] : idx_m1;

	i2r_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (rem_c[DIV_STEP]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer with output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			div_q    <= '0;
			rem_q    <= '0;
			chunk_q  <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			neg_q    <= 1'b0;
			ovalid_q <= 1'b0;
			char_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			if (dout.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						div_q   <= PAD_W'(pop_data[VALUE_WIDTH-1:0]);
						neg_q   <= pop_data[VALUE_WIDTH];
						rem_q   <= '0;
						chunk_q <= '0;
						count_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_q <= next_div;
					if (last_chunk) begin
						rem_q   <= '0;
						chunk_q <= '0;
						if (count_q != CNT_W'(MAX_DIGITS)) begin
							count_q <= count_q + 1'b1;
						end
						if (next_div == '0) begin
							state_q <= ST_SIGN;
						end
					end else begin
						rem_q   <= rem_c[DIV_STEP];
						chunk_q <= chunk_q + 1'b1;
					end
				end
				ST_SIGN: begin
					idx_q <= cnt_m1[AW-1:0];
					if (!neg_q) begin
						state_q <= ST_EMIT;
					end else if (out_free) begin
						char_q   <= MINUS_CHAR;
						last_q   <= 1'b0;
						ovalid_q <= 1'b1;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						char_q   <= symbol_of(ram_rdata, cfg);
						last_q   <= (idx_q == '0);
						ovalid_q <= 1'b1;
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_m1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign dout.valid     = ovalid_q;
	assign dout.out_char  = char_q;
	assign dout.last_char = last_q;
endmodule

>>> rtl/core/signed_integer_to_radix_digits.sv
// each value is divided by the radix once per digit, each time in one pass over the padded dividend,
// and a leading minus goes out ahead of the leading digit
// characters then leave at one per cycle while the output is not stalled; the minus is registered in
// the sign state after the divider, so an item takes as long with or without sign, plus output stalls
// a two-entry queue takes further values while the divider and the character stage are busy
// reset is asynchronous active low: radix 10, alphabet "0123456789abcdef", queue and engine empty
module signed_integer_to_radix_digits import i2r_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_RADIX   = 16,
	parameter int MAX_DIGITS  = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	i2r_in_if.sink                 din,
	i2r_out_if.source              dout
);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(MAX_RADIX);

	logic [RADIX_W-1:0]    radix_q;
	logic [CFG_DATA_W-1:0] chars_low_q;
	logic [CFG_DATA_W-1:0] chars_high_q;
	logic [RADIX_W-1:0]    eff_radix;
	cfg_t                  cfg;

	logic                   push_valid;
	logic                   push_ready;
	logic [VALUE_WIDTH:0]   push_data;
	logic                   pop_valid;
	logic                   pop_ready;
	logic [VALUE_WIDTH:0]   pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q      <= RADIX_RESET;
			chars_low_q  <= CHARS_LOW_RESET;
			chars_high_q <= CHARS_HIGH_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RADIX:      radix_q      <= cfg_wdata[RADIX_W-1:0];
				REG_CHARS_LOW:  chars_low_q  <= cfg_wdata;
				REG_CHARS_HIGH: chars_high_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// clamp the radix into the supported range
	always_comb begin
		eff_radix = radix_q;
		if (radix_q < RADIX_MIN) begin
			eff_radix = RADIX_MIN;
		end
		if (radix_q > RADIX_MAX) begin
			eff_radix = RADIX_MAX;
		end
	end

	assign cfg.radix      = eff_radix;
	assign cfg.chars_low  = chars_low_q;
	assign cfg.chars_high = chars_high_q;

	i2r_front #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.din        (din),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	i2r_fifo #(
		.DATA_W (VALUE_WIDTH + 1),
		.DEPTH  (2)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	i2r_back #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.dout      (dout)
	);
endmodule

>>> rtl/core/i2r_checker.sv
// port level checker for the radix conversion block, bound to the top level
`include "signed_integer_to_radix_digits_assert.svh"
module i2r_checker import i2r_pkg::*; #(
	parameter int MAX_DIGITS = 32
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] out_char,
	input logic              out_last
);
	localparam int RUN_W = $clog2(MAX_DIGITS + 2);

	logic [3:0]       pending_q;
	logic [RUN_W-1:0] run_q;
	logic             in_xfer;
	logic             out_xfer;
	logic             end_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign end_xfer = out_xfer && out_last;

	// numbers taken but not yet finished, and characters of the current number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			run_q     <= '0;
		end else begin
			if (in_xfer && !end_xfer) begin
				pending_q <= pending_q + 1'b1;
			end else if (end_xfer && !in_xfer) begin
				pending_q <= pending_q - 1'b1;
			end
			if (end_xfer) begin
				run_q <= '0;
			end else if (out_xfer) begin
				run_q <= run_q + 1'b1;
			end
		end
	end

	`I2R_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid,
		"output valid dropped while stalled")
	`I2R_ASSERT_NEXT(a_payload_hold, out_valid && !out_ready,
		$stable(out_char) && $stable(out_last), "output payload changed while stalled")
	`I2R_ASSERT_SAME(a_end_has_item, end_xfer, pending_q != '0,
		"number ended with no value taken")
	`I2R_ASSERT_SAME(a_run_bound, out_xfer, run_q <= RUN_W'(MAX_DIGITS),
		"number longer than sign plus maximum digit count")
endmodule

bind signed_integer_to_radix_digits i2r_checker #(
	.MAX_DIGITS (MAX_DIGITS)
) u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_char  (dout.out_char),
	.out_last  (dout.last_char)
);
